[design/gcew_pkg.sv]
// ----------------------------------------------------------------------------
// Graph-cut edge weight generator package
// Shared widths, register indexes, interface structs and arithmetic helpers.
// ----------------------------------------------------------------------------
package gcew_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int DIM_W      = 11;
    localparam int GAIN_W     = 16;
    localparam int NODE_W     = 21;
    localparam int CAP_W      = 32;
    localparam int COST_W     = 32;
    localparam int DIFF_W     = 18;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 21;
    localparam int BETA_W     = 32;
    localparam int NUM_W      = CNT_W + 16;
    localparam int DEN_W      = SUM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COLOR_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHNESS_GAIN = 2'd2;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [GAIN_W-1:0] RST_GAIN         = 16'd12800;

    localparam logic [30:0]       LOG2E_Q30 = 31'd1549082005;
    localparam logic [BETA_W-1:0] BETA_HALF = 32'h0000_8000;
    localparam logic [BETA_W-1:0] BETA_SAT  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] diff;
    } wt_req_t;

    typedef struct packed {
        logic             done;
        logic [CAP_W-1:0] weight;
    } wt_rsp_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [BETA_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    function automatic logic [DIFF_W-1:0] color_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [7:0]        ca;
        logic [7:0]        cb;
        logic [7:0]        d;
        logic [DIFF_W-1:0] s;
        s = '0;
        for (int k = 0; k < 3; k++)
        begin
            ca = a[8*k +: 8];
            cb = b[8*k +: 8];
            d  = (ca > cb) ? (ca - cb) : (cb - ca);
            s  = s + ({10'b0, d} * {10'b0, d});
        end
        return s;
    endfunction

endpackage

[design/gcew_div.sv]
// ----------------------------------------------------------------------------
// Contrast divider
// Restoring divider, one quotient bit per cycle, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module gcew_div
    import gcew_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic [5:0]       cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    div_rsp_t         rsp_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_new;
    logic [NUM_W-1:0] quo_new;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_new = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            rsp_reg  <= '0;
        end
        else
        begin
            rsp_reg.done <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NUM_W);
                quo_reg  <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                quo_reg <= quo_new;
                rem_reg <= rem_new[DEN_W-1:0];
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg     <= 1'b0;
                    rsp_reg.done <= 1'b1;
                    if (quo_new[NUM_W-1:BETA_W] != '0)
                        rsp_reg.quotient <= BETA_SAT;
                    else
                        rsp_reg.quotient <= quo_new[BETA_W-1:0];
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

[design/gcew_weight.sv]
// ----------------------------------------------------------------------------
// Link weight unit
// Computes lambda * exp(-beta * diff) in fixed point with one shared
// multiplier, stepped through up to four products by a small sequencer.
// ----------------------------------------------------------------------------
module gcew_weight
    import gcew_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wt_req_t           req,
    input  logic [BETA_W-1:0] beta,
    input  logic [GAIN_W-1:0] gain,
    output wt_rsp_t           rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_MT, S_CT, S_MU, S_CU, S_MI, S_CI, S_ME, S_CE
    } state_t;

    state_t      state_reg;
    logic [31:0] op_a_reg;
    logic [31:0] op_b_reg;
    logic [63:0] prod_reg;
    logic [4:0]  n_reg;
    logic [3:0]  i_reg;
    wt_rsp_t     rsp_reg;

    logic [22:0] u_w;
    logic [16:0] tab_step;
    logic [16:0] m_w;
    logic [16:0] e_w;

    always_comb
    begin
        u_w      = prod_reg[52:30];
        tab_step = pow2_neg({1'b0, u_w[15:12]}) - pow2_neg({1'b0, u_w[15:12]} + 5'd1);
        m_w      = pow2_neg({1'b0, i_reg}) - prod_reg[28:12];
        e_w      = m_w >> n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_a_reg  <= '0;
            op_b_reg  <= '0;
            prod_reg  <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            prod_reg     <= {32'b0, op_a_reg} * {32'b0, op_b_reg};
            rsp_reg.done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        op_a_reg  <= beta;
                        op_b_reg  <= {14'b0, req.diff};
                        state_reg <= S_MT;
                    end
                end
                S_MT: state_reg <= S_CT;
                S_CT:
                begin
                    if (prod_reg[63:22] != '0)
                    begin
                        rsp_reg.done   <= 1'b1;
                        rsp_reg.weight <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        op_a_reg  <= {10'b0, prod_reg[21:0]};
                        op_b_reg  <= {1'b0, LOG2E_Q30};
                        state_reg <= S_MU;
                    end
                end
                S_MU: state_reg <= S_CU;
                S_CU:
                begin
                    if (u_w[22:16] >= 7'd17)
                    begin
                        rsp_reg.done   <= 1'b1;
                        rsp_reg.weight <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        n_reg     <= u_w[20:16];
                        i_reg     <= u_w[15:12];
                        op_a_reg  <= {15'b0, tab_step};
                        op_b_reg  <= {20'b0, u_w[11:0]};
                        state_reg <= S_MI;
                    end
                end
                S_MI: state_reg <= S_CI;
                S_CI:
                begin
                    op_a_reg  <= {16'b0, gain};
                    op_b_reg  <= {15'b0, e_w};
                    state_reg <= S_ME;
                end
                S_ME: state_reg <= S_CE;
                S_CE:
                begin
                    rsp_reg.done   <= 1'b1;
                    rsp_reg.weight <= prod_reg[39:8];
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

[design/graph_cut_edge_weight_generator_unit.sv]
// ----------------------------------------------------------------------------
// Graph-cut edge weight generator
// A statistics beat runs the difference and two accumulation states; the
// frame's last one then waits on the one-bit-per-cycle beta divider. An edge
// beat computes the differences, waits on the shared-multiplier weight unit
// for each neighbour link weight and sends its edges (two, four or six) one
// per cycle while the output is not stalled. The input is stalled for that
// whole time. The row buffer is a single-port memory of MAX_WIDTH colours.
// ----------------------------------------------------------------------------
module graph_cut_edge_weight_generator_unit
    import gcew_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_enable,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [COST_W-1:0]     background_cost,
    input  logic [COST_W-1:0]     foreground_cost,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [NODE_W-1:0]     from_node,
    output logic [NODE_W-1:0]     to_node,
    output logic [CAP_W-1:0]      capacity,
    output logic                  last_edge
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = YW + WW;
    localparam int NW = WW + HW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_ACC_L, ST_ACC_U, ST_BETA, ST_DIV,
        ST_WL_GO, ST_WL_WAIT, ST_WU_GO, ST_WU_WAIT, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SL_SRC, SL_SINK, SL_L_IN, SL_L_OUT, SL_U_IN, SL_U_OUT
    } slot_t;

    state_t              state_reg;
    slot_t               slot_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [XW-1:0]       col_reg;
    logic [YW-1:0]       row_reg;
    logic [COLOR_W-1:0]  prev_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [BETA_W-1:0]   beta_reg;

    logic                cmd_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [COLOR_W-1:0]  left_reg;
    logic [COST_W-1:0]   bg_reg;
    logic [COST_W-1:0]   fg_reg;
    logic [XW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    logic [WW-1:0]       w_reg;
    logic [HW-1:0]       h_reg;
    logic                has_l_reg;
    logic                has_u_reg;
    logic                last_pos_reg;
    logic [DIFF_W-1:0]   dl_reg;
    logic [DIFF_W-1:0]   du_reg;
    logic [NODE_W-1:0]   p_reg;
    logic [NODE_W-1:0]   nodes_reg;
    logic [CAP_W-1:0]    wl_reg;
    logic [CAP_W-1:0]    wu_reg;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   from_reg;
    logic [NODE_W-1:0]   to_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                last_reg;

    logic [COLOR_W-1:0]  line_mem [MAX_WIDTH];
    logic [COLOR_W-1:0]  up_rd_reg;

    logic [WW-1:0]       w_eff;
    logic [HW-1:0]       h_eff;
    logic [XW-1:0]       x_cur;
    logic [YW-1:0]       y_cur;
    logic                last_x;
    logic                last_y;
    logic                in_acc;
    logic [COLOR_W-1:0]  color_in;
    logic [DIFF_W-1:0]   add_op;
    logic [SUM_W:0]      sum_add;
    logic [PW-1:0]       p_full;
    logic [NW-1:0]       nodes_full;
    logic                out_free;
    slot_t               slot_next;
    logic                slot_last;
    logic [NODE_W-1:0]   e_from;
    logic [NODE_W-1:0]   e_to;
    logic [CAP_W-1:0]    e_cap;

    wt_req_t             wt_req;
    wt_rsp_t             wt_rsp;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if ({21'b0, width_reg} > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if ({21'b0, height_reg} > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);

        x_cur    = (WW'(col_reg) < w_eff) ? col_reg : '0;
        y_cur    = (HW'(row_reg) < h_eff) ? row_reg : '0;
        last_x   = (WW'(x_cur) == (w_eff - WW'(1)));
        last_y   = (HW'(y_cur) == (h_eff - HW'(1)));
        in_acc   = in_valid && !in_stall;
        color_in = {blue, green, red};

        add_op  = (state_reg == ST_ACC_L) ? dl_reg : du_reg;
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(add_op);

        p_full     = PW'(y_reg) * PW'(w_reg) + PW'(x_reg);
        nodes_full = NW'(w_reg) * NW'(h_reg);

        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        case (slot_reg)
            SL_SRC:
            begin
                slot_next = SL_SINK;
                slot_last = 1'b0;
                e_from    = nodes_reg;
                e_to      = p_reg;
                e_cap     = bg_reg;
            end
            SL_SINK:
            begin
                slot_next = has_l_reg ? SL_L_IN : SL_U_IN;
                slot_last = !has_l_reg && !has_u_reg;
                e_from    = p_reg;
                e_to      = nodes_reg + NODE_W'(1);
                e_cap     = fg_reg;
            end
            SL_L_IN:
            begin
                slot_next = SL_L_OUT;
                slot_last = 1'b0;
                e_from    = p_reg - NODE_W'(1);
                e_to      = p_reg;
                e_cap     = wl_reg;
            end
            SL_L_OUT:
            begin
                slot_next = SL_U_IN;
                slot_last = !has_u_reg;
                e_from    = p_reg;
                e_to      = p_reg - NODE_W'(1);
                e_cap     = wl_reg;
            end
            SL_U_IN:
            begin
                slot_next = SL_U_OUT;
                slot_last = 1'b0;
                e_from    = p_reg - NODE_W'(w_reg);
                e_to      = p_reg;
                e_cap     = wu_reg;
            end
            SL_U_OUT:
            begin
                slot_next = SL_SRC;
                slot_last = 1'b1;
                e_from    = p_reg;
                e_to      = p_reg - NODE_W'(w_reg);
                e_cap     = wu_reg;
            end
            default:
            begin
                slot_next = SL_SRC;
                slot_last = 1'b1;
                e_from    = '0;
                e_to      = '0;
                e_cap     = '0;
            end
        endcase
    end

    always_comb
    begin
        wt_req.start = ((state_reg == ST_WL_GO) && has_l_reg) ||
                       ((state_reg == ST_WU_GO) && has_u_reg);
        wt_req.diff  = (state_reg == ST_WL_GO) ? dl_reg : du_reg;

        div_req.start = (state_reg == ST_BETA) && (cnt_reg != '0) && (sum_reg != '0);
        div_req.num   = {cnt_reg, 16'b0};
        div_req.den   = {sum_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            up_rd_reg       <= line_mem[x_cur];
            line_mem[x_cur] <= color_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= SL_SRC;
            width_reg     <= RST_FRAME_WIDTH;
            height_reg    <= RST_FRAME_HEIGHT;
            gain_reg      <= RST_GAIN;
            col_reg       <= '0;
            row_reg       <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            beta_reg      <= BETA_HALF;
            cmd_reg       <= 1'b0;
            color_reg     <= '0;
            left_reg      <= '0;
            bg_reg        <= '0;
            fg_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            has_l_reg     <= 1'b0;
            has_u_reg     <= 1'b0;
            last_pos_reg  <= 1'b0;
            dl_reg        <= '0;
            du_reg        <= '0;
            p_reg         <= '0;
            nodes_reg     <= '0;
            wl_reg        <= '0;
            wu_reg        <= '0;
            out_valid_reg <= 1'b0;
            from_reg      <= '0;
            to_reg        <= '0;
            cap_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg      <= command;
                        color_reg    <= color_in;
                        left_reg     <= prev_reg;
                        bg_reg       <= background_cost;
                        fg_reg       <= foreground_cost;
                        x_reg        <= x_cur;
                        y_reg        <= y_cur;
                        w_reg        <= w_eff;
                        h_reg        <= h_eff;
                        has_l_reg    <= (x_cur != '0);
                        has_u_reg    <= (y_cur != '0);
                        last_pos_reg <= last_x && last_y;
                        prev_reg     <= color_in;
                        if (!command && (x_cur == '0) && (y_cur == '0))
                        begin
                            sum_reg <= '0;
                            cnt_reg <= '0;
                        end
                        if (last_x)
                        begin
                            col_reg <= '0;
                            row_reg <= last_y ? '0 : (y_cur + YW'(1));
                        end
                        else
                        begin
                            col_reg <= x_cur + XW'(1);
                            row_reg <= y_cur;
                        end
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    dl_reg    <= color_diff(color_reg, left_reg);
                    du_reg    <= color_diff(color_reg, up_rd_reg);
                    p_reg     <= NODE_W'(p_full);
                    nodes_reg <= NODE_W'(nodes_full);
                    state_reg <= cmd_reg ? ST_WL_GO : ST_ACC_L;
                end
                ST_ACC_L, ST_ACC_U:
                begin
                    if ((state_reg == ST_ACC_L) ? has_l_reg : has_u_reg)
                    begin
                        sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        if (cnt_reg != '1)
                            cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (state_reg == ST_ACC_L)
                        state_reg <= ST_ACC_U;
                    else
                        state_reg <= last_pos_reg ? ST_BETA : ST_IDLE;
                end
                ST_BETA:
                begin
                    if (cnt_reg == '0)
                    begin
                        beta_reg  <= BETA_HALF;
                        state_reg <= ST_IDLE;
                    end
                    else if (sum_reg == '0)
                    begin
                        beta_reg  <= BETA_SAT;
                        state_reg <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        beta_reg  <= div_rsp.quotient;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WL_GO:   state_reg <= has_l_reg ? ST_WL_WAIT : ST_WU_GO;
                ST_WL_WAIT:
                begin
                    if (wt_rsp.done)
                    begin
                        wl_reg    <= wt_rsp.weight;
                        state_reg <= ST_WU_GO;
                    end
                end
                ST_WU_GO:
                begin
                    slot_reg  <= SL_SRC;
                    state_reg <= has_u_reg ? ST_WU_WAIT : ST_EMIT;
                end
                ST_WU_WAIT:
                begin
                    if (wt_rsp.done)
                    begin
                        wu_reg    <= wt_rsp.weight;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        from_reg      <= e_from;
                        to_reg        <= e_to;
                        cap_reg       <= e_cap;
                        last_reg      <= slot_last;
                        slot_reg      <= slot_next;
                        if (slot_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_write_enable)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg <= cfg_data[DIM_W-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg <= cfg_data[DIM_W-1:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    REG_SMOOTHNESS_GAIN: gain_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    gcew_weight u_weight
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wt_req),
        .beta  (beta_reg),
        .gain  (gain_reg),
        .rsp   (wt_rsp)
    );

    gcew_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign from_node = from_reg;
    assign to_node   = to_reg;
    assign capacity  = cap_reg;
    assign last_edge = last_reg;

`ifndef SYNTH
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the beta state");

    a_wt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        wt_rsp.done |-> (state_reg == ST_WL_WAIT || state_reg == ST_WU_WAIT))
        else $error("weight unit finished while no weight was awaited");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input beat accepted without entering the busy sequence");
`endif

endmodule

[tb/sv/graph_cut_edge_weight_generator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph-cut edge weight generator testbench
// Drives statistics and edge passes over small frames, predicts every edge
// with an independent fixed-point model of beta and the link weights, and
// checks each output beat in order under random idling on both channels.
// ----------------------------------------------------------------------------
module graph_cut_edge_weight_generator_unit_tb;
    import gcew_pkg::*;

    localparam logic CMD_STATS = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [CAP_W-1:0]  capacity;
        logic              last_edge;
    } edge_t;

    localparam logic [16:0] EXP2_TABLE [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_enable;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [COST_W-1:0]     background_cost;
    logic [COST_W-1:0]     foreground_cost;
    logic                  out_valid;
    logic                  out_stall;
    logic [NODE_W-1:0]     from_node;
    logic [NODE_W-1:0]     to_node;
    logic [CAP_W-1:0]      capacity;
    logic                  last_edge;

    graph_cut_edge_weight_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .command(command),
        .red(red), .green(green), .blue(blue),
        .background_cost(background_cost), .foreground_cost(foreground_cost),
        .out_valid(out_valid), .out_stall(out_stall),
        .from_node(from_node), .to_node(to_node), .capacity(capacity),
        .last_edge(last_edge)
    );

    edge_t       pending_edges[$];
    int          failures = 0;
    bit          steady = 0;
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] gain_reg;
    int unsigned column_pos;
    int unsigned row_pos;
    logic [23:0] left_color;
    logic [23:0] line_colors [0:DEF_MAX_WIDTH-1];
    logic [63:0] diff_total;
    logic [63:0] pair_total;
    logic [31:0] beta;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 27);
    end

    always @(posedge clk)
    begin
        edge_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("unexpected edge %0d -> %0d", from_node, to_node);
                failures++;
            end
            else
            begin
                want = pending_edges.pop_front();
                if (from_node !== want.from_node)
                begin
                    $error("from_node expected %0d got %0d", want.from_node, from_node);
                    failures++;
                end
                if (to_node !== want.to_node)
                begin
                    $error("to_node expected %0d got %0d", want.to_node, to_node);
                    failures++;
                end
                if (capacity !== want.capacity)
                begin
                    $error("capacity expected %0h got %0h", want.capacity, capacity);
                    failures++;
                end
                if (last_edge !== want.last_edge)
                begin
                    $error("last_edge expected %0d got %0d", want.last_edge, last_edge);
                    failures++;
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(logic [10:0] value);
        if (value == 0)
            return 1;
        if (value > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return value;
    endfunction

    function automatic int unsigned colour_distance(logic [23:0] a, logic [23:0] b);
        int unsigned sum;
        int          d;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic logic [31:0] smoothness_weight(int unsigned distance);
        logic [63:0] t;
        logic [63:0] u;
        int unsigned n;
        int unsigned seg;
        logic [63:0] frac;
        logic [63:0] m;
        logic [63:0] scaled;
        t = 64'(beta) * 64'(distance);
        if ((t >> 22) != 0)
            return '0;
        u = (t * 64'(LOG2E_Q30)) >> 30;
        n = 32'(u >> 16);
        if (n >= 17)
            return '0;
        seg = 32'((u >> 12) & 64'hF);
        frac = u & 64'hFFF;
        m = EXP2_TABLE[seg] - (((EXP2_TABLE[seg] - EXP2_TABLE[seg + 1]) * frac) >> 12);
        scaled = (64'(gain_reg) * (m >> n)) >> 8;
        return scaled[31:0];
    endfunction

    function automatic void add_pair(int unsigned distance);
        diff_total += distance;
        if (diff_total > 64'hFF_FFFF_FFFF)
            diff_total = 64'hFF_FFFF_FFFF;
        if (pair_total < 64'h1F_FFFF)
            pair_total++;
    endfunction

    function automatic void predict_pixel(logic cmd, logic [23:0] colour,
                                          logic [31:0] bg, logic [31:0] fg);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned p;
        int unsigned nodes;
        logic [23:0] above;
        logic [31:0] wt;
        edge_t       edges[$];
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        x = (column_pos < w) ? column_pos : 0;
        y = (row_pos < h) ? row_pos : 0;
        above = line_colors[x];
        if (cmd == CMD_STATS)
        begin
            if (x == 0 && y == 0)
            begin
                diff_total = 0;
                pair_total = 0;
            end
            if (x > 0)
                add_pair(colour_distance(colour, left_color));
            if (y > 0)
                add_pair(colour_distance(colour, above));
            if (x == w - 1 && y == h - 1)
            begin
                if (pair_total == 0)
                    beta = 32'h8000;
                else if (diff_total == 0)
                    beta = 32'hFFFF_FFFF;
                else if (((pair_total << 16) / (2 * diff_total)) > 64'hFFFF_FFFF)
                    beta = 32'hFFFF_FFFF;
                else
                    beta = 32'((pair_total << 16) / (2 * diff_total));
            end
        end
        else
        begin
            nodes = w * h;
            p = y * w + x;
            edges.push_back('{21'(nodes), 21'(p), bg, 1'b0});
            edges.push_back('{21'(p), 21'(nodes + 1), fg, 1'b0});
            if (x > 0)
            begin
                wt = smoothness_weight(colour_distance(colour, left_color));
                edges.push_back('{21'(p - 1), 21'(p), wt, 1'b0});
                edges.push_back('{21'(p), 21'(p - 1), wt, 1'b0});
            end
            if (y > 0)
            begin
                wt = smoothness_weight(colour_distance(colour, above));
                edges.push_back('{21'(p - w), 21'(p), wt, 1'b0});
                edges.push_back('{21'(p), 21'(p - w), wt, 1'b0});
            end
            edges[edges.size() - 1].last_edge = 1'b1;
            foreach (edges[k])
                pending_edges.push_back(edges[k]);
        end
        left_color = colour;
        line_colors[x] = colour;
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        column_pos = x;
        row_pos = y;
    endfunction

    task automatic send_pixel(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [31:0] bg, logic [31:0] fg);
        if (!steady && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= cmd;
        red             <= r;
        green           <= g;
        blue            <= b;
        background_cost <= bg;
        foreground_cost <= fg;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(cmd, {b, g, r}, bg, fg);
    endtask

    task automatic send_random_pixel(logic cmd);
        send_pixel(cmd, 8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        drain();
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
        begin
            width_reg = value[10:0];
            column_pos = 0;
            row_pos = 0;
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            height_reg = value[10:0];
            column_pos = 0;
            row_pos = 0;
        end
        else if (idx == REG_SMOOTHNESS_GAIN)
            gain_reg = value;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, logic [15:0] gain);
        write_reg(REG_FRAME_WIDTH, 16'(w));
        write_reg(REG_FRAME_HEIGHT, 16'(h));
        write_reg(REG_SMOOTHNESS_GAIN, gain);
    endtask

    task automatic test_reset_state;
        send_pixel(CMD_EDGE, 8'h00, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF);
        send_pixel(CMD_EDGE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
        send_pixel(CMD_EDGE, 8'hFE, 8'hFF, 8'hFF, 32'h1234_5678, 32'h8765_4321);
        send_pixel(CMD_STATS, 8'h10, 8'h20, 8'h30, 32'h0, 32'h0);
    endtask

    task automatic test_single_pixel_frame;
        set_frame(1, 1, 16'd256);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pixel(CMD_STATS, 8'hAA, 8'h55, 8'h0F, 32'h0, 32'h0);
        send_pixel(CMD_EDGE, 8'h12, 8'h34, 8'h56, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    endtask

    task automatic test_flat_frame;
        set_frame(2, 2, 16'hFFFF);
        repeat (4) send_pixel(CMD_STATS, 8'h80, 8'h80, 8'h80, 32'h0, 32'h0);
        send_pixel(CMD_EDGE, 8'h80, 8'h80, 8'h80, 32'h1, 32'h2);
        send_pixel(CMD_EDGE, 8'h80, 8'h80, 8'h80, 32'h3, 32'h4);
        send_pixel(CMD_EDGE, 8'h81, 8'h80, 8'h80, 32'h5, 32'h6);
        send_pixel(CMD_EDGE, 8'h80, 8'h80, 8'h80, 32'h7, 32'h8);
    endtask

    task automatic test_dimension_clamp;
        set_frame(2047, 0, 16'd0);
        repeat (3) send_random_pixel(CMD_EDGE);
        write_reg(REG_FRAME_WIDTH, 16'hF800);
        repeat (2) send_random_pixel(CMD_EDGE);
    endtask

    task automatic test_random_frames;
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        logic [7:0]  base;
        sent = 0;
        while (sent < 60)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            steady = ($urandom_range(3) == 0);
            case ($urandom_range(3))
                0:       set_frame(w, h, 16'hFFFF);
                1:       set_frame(w, h, 16'd0);
                default: set_frame(w, h, 16'($urandom));
            endcase
            base = 8'($urandom);
            for (int pass = 0; pass < 2; pass++)
                for (int k = 0; k < w * h; k++)
                begin
                    if ($urandom_range(9) == 0)
                        send_random_pixel(1'($urandom));
                    else if ($urandom_range(1))
                        send_pixel(pass ? CMD_EDGE : CMD_STATS,
                                   base + 8'($urandom_range(3)), base - 8'($urandom_range(3)),
                                   base ^ 8'($urandom_range(1)), $urandom, $urandom);
                    else
                        send_random_pixel(pass ? CMD_EDGE : CMD_STATS);
                    sent++;
                end
        end
        steady = 0;
    endtask

    task automatic test_output_backpressure;
        set_frame(4, 3, 16'd12800);
        repeat (12) send_random_pixel(CMD_STATS);
        drain();
        hold_request++;
        repeat (12) send_random_pixel(CMD_EDGE);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        command          = 1'b0;
        red              = '0;
        green            = '0;
        blue             = '0;
        background_cost  = '0;
        foreground_cost  = '0;
        out_stall        = 1'b0;
        width_reg        = RST_FRAME_WIDTH;
        height_reg       = RST_FRAME_HEIGHT;
        gain_reg         = RST_GAIN;
        column_pos       = 0;
        row_pos          = 0;
        left_color       = '0;
        diff_total       = 0;
        pair_total       = 0;
        beta             = BETA_HALF;
        foreach (line_colors[k])
            line_colors[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_pixel_frame();
        test_flat_frame();
        test_dimension_clamp();
        test_random_frames();
        test_output_backpressure();
        drain();

        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[graph_cut_edge_weight_generator_unit.f]
design/gcew_pkg.sv
design/gcew_div.sv
design/gcew_weight.sv
design/graph_cut_edge_weight_generator_unit.sv
tb/sv/graph_cut_edge_weight_generator_unit_tb.sv
